// File: rtl/swb_pkg.sv
// swept box collision test: shared constants, payload structs and pipeline types
// used by every file under rtl; depends on nothing
package swb_pkg;

    localparam int COORD_BITS     = 16;
    localparam int TIME_FRAC_BITS = 16;
    localparam int SIZE_BITS      = COORD_BITS - 1;
    localparam int TOL_BITS       = 8;
    localparam int LEN_BITS       = 16;
    localparam int EDGE_BITS      = COORD_BITS + 3;
    localparam int DEN_BITS       = COORD_BITS + 1;
    localparam int TIME_BITS      = TIME_FRAC_BITS + 1;
    localparam int PROD_BITS      = EDGE_BITS + TIME_BITS + 1;
    localparam int DIV_STAGES     = 4;
    localparam int DIV_STEP       = (TIME_FRAC_BITS + DIV_STAGES - 1) / DIV_STAGES;

    localparam logic [TOL_BITS-1:0]  TOL_RESET   = TOL_BITS'(1);
    localparam logic [TIME_BITS-1:0] TIME_ONE    = TIME_BITS'(1) << TIME_FRAC_BITS;
    localparam logic [LEN_BITS-1:0]  CONTACT_MAX = {LEN_BITS{1'b1}};

    typedef logic signed [EDGE_BITS-1:0] edge_t;
    typedef logic [DEN_BITS-1:0]         den_t;
    typedef logic [TIME_BITS-1:0]        time_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] moving_x;
        logic signed [COORD_BITS-1:0] moving_y;
        logic signed [COORD_BITS-1:0] moving_last_x;
        logic signed [COORD_BITS-1:0] moving_last_y;
        logic [SIZE_BITS-1:0]         moving_width;
        logic [SIZE_BITS-1:0]         moving_height;
        logic signed [COORD_BITS-1:0] static_x;
        logic signed [COORD_BITS-1:0] static_y;
        logic [SIZE_BITS-1:0]         static_width;
        logic [SIZE_BITS-1:0]         static_height;
        logic                         one_way;
    } in_t;

    typedef struct packed {
        logic                 hit;
        logic                 hit_axis;
        logic [TIME_BITS-1:0] hit_time;
        logic [LEN_BITS-1:0]  contact_length;
        logic                 touch_top;
        logic                 touch_bottom;
        logic                 touch_left;
        logic                 touch_right;
    } out_t;

    // per-item state carried from the edge tests through the divider
    typedef struct packed {
        logic  cx;
        logic  cy;
        logic  crossed_y;
        logic  t_left;
        logic  t_right;
        logic  t_top;
        logic  t_bot;
        den_t  num_x;
        den_t  den_x;
        den_t  num_y;
        den_t  den_y;
        edge_t dx;
        edge_t dy;
        edge_t lml;
        edge_t lmb;
        edge_t mw;
        edge_t mh;
        edge_t sl;
        edge_t sr;
        edge_t sb;
        edge_t st;
        edge_t sl_tol;
        edge_t sr_tol;
        edge_t sb_tol;
        edge_t st_tol;
    } front_t;

endpackage

// File: rtl/swb_front.sv
// swept box collision test: edge arithmetic, sweep and crossing tests, first stage
// depends on swb_pkg
module swb_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  swb_pkg::in_t                 in_data,
    input  logic [swb_pkg::TOL_BITS-1:0] tol,
    output logic                         valid,
    output swb_pkg::front_t              front
);

    swb_pkg::edge_t ml, mb, lml, lmb, mw, mh, sl, sb, sr, st, mr, mt, lmr, lmt, tol_e;
    swb_pkg::edge_t sl_tol, sr_tol, sb_tol, st_tol;
    swb_pkg::edge_t nx_raw, dx_raw, ny_raw, dy_raw, nxc, nyc;
    logic sweep_x, sweep_y, cr_r, cr_l, cr_b, cr_t;
    swb_pkg::front_t front_next;
    logic valid_reg;
    swb_pkg::front_t front_reg;

    always_comb
    begin
        ml  = swb_pkg::edge_t'(in_data.moving_x);
        mb  = swb_pkg::edge_t'(in_data.moving_y);
        lml = swb_pkg::edge_t'(in_data.moving_last_x);
        lmb = swb_pkg::edge_t'(in_data.moving_last_y);
        mw  = swb_pkg::edge_t'(in_data.moving_width);
        mh  = swb_pkg::edge_t'(in_data.moving_height);
        sl  = swb_pkg::edge_t'(in_data.static_x);
        sb  = swb_pkg::edge_t'(in_data.static_y);
        sr  = sl + swb_pkg::edge_t'(in_data.static_width);
        st  = sb + swb_pkg::edge_t'(in_data.static_height);
        tol_e = swb_pkg::edge_t'(tol);
        mr  = ml + mw;
        mt  = mb + mh;
        lmr = lml + mw;
        lmt = lmb + mh;
        sl_tol = sl + tol_e;
        sr_tol = sr - tol_e;
        sb_tol = sb + tol_e;
        st_tol = st - tol_e;

        sweep_x = (((mb < lmb) ? mb : lmb) < st_tol) && (((mt > lmt) ? mt : lmt) > sb_tol);
        sweep_y = (((ml < lml) ? ml : lml) < sr_tol) && (((mr > lmr) ? mr : lmr) > sl_tol);
        cr_r = (lmr <= sl_tol) && (mr > sl_tol);
        cr_l = !cr_r && (lml >= sr_tol) && (ml < sr_tol);
        cr_b = (lmt <= sb_tol) && (mt > sb_tol);
        cr_t = !cr_b && (lmb >= st_tol) && (mb < st_tol);

        nx_raw = cr_r ? (sl - lmr) : (lml - sr);
        dx_raw = cr_r ? (ml - lml) : (lml - ml);
        ny_raw = cr_b ? (sb - lmt) : (lmb - st);
        dy_raw = cr_b ? (mb - lmb) : (lmb - mb);
        // entry fraction numerator clamped to 0..den
        nxc = (nx_raw < 0) ? '0 : ((nx_raw > dx_raw) ? dx_raw : nx_raw);
        nyc = (ny_raw < 0) ? '0 : ((ny_raw > dy_raw) ? dy_raw : ny_raw);

        front_next.cx        = sweep_x && (cr_r || cr_l);
        front_next.t_right   = sweep_x && cr_r;
        front_next.t_left    = sweep_x && cr_l;
        front_next.crossed_y = sweep_y && (cr_b || cr_t);
        front_next.cy        = sweep_y && (cr_b || (cr_t && !in_data.one_way));
        front_next.t_bot     = sweep_y && cr_b;
        front_next.t_top     = sweep_y && cr_t;
        front_next.num_x     = swb_pkg::den_t'(nxc);
        front_next.den_x     = swb_pkg::den_t'(dx_raw);
        front_next.num_y     = swb_pkg::den_t'(nyc);
        front_next.den_y     = swb_pkg::den_t'(dy_raw);
        front_next.dx        = ml - lml;
        front_next.dy        = mb - lmb;
        front_next.lml       = lml;
        front_next.lmb       = lmb;
        front_next.mw        = mw;
        front_next.mh        = mh;
        front_next.sl        = sl;
        front_next.sr        = sr;
        front_next.sb        = sb;
        front_next.st        = st;
        front_next.sl_tol    = sl_tol;
        front_next.sr_tol    = sr_tol;
        front_next.sb_tol    = sb_tol;
        front_next.st_tol    = st_tol;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    assign valid = valid_reg;
    assign front = front_reg;

endmodule

// File: rtl/swb_div.sv
// swept box collision test: pipelined restoring dividers for both entry times
// depends on swb_pkg; carries the item state alongside the quotients
module swb_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  swb_pkg::front_t        in_front,
    output logic                   valid,
    output swb_pkg::front_t        front,
    output swb_pkg::time_t         tx,
    output swb_pkg::time_t         ty
);

    typedef struct packed {
        swb_pkg::den_t  rem;
        swb_pkg::den_t  den;
        swb_pkg::time_t q;
    } lane_t;

    lane_t           x_reg [swb_pkg::DIV_STAGES];
    lane_t           y_reg [swb_pkg::DIV_STAGES];
    swb_pkg::front_t f_reg [swb_pkg::DIV_STAGES];
    logic            v_reg [swb_pkg::DIV_STAGES];
    lane_t           x_next [swb_pkg::DIV_STAGES];
    lane_t           y_next [swb_pkg::DIV_STAGES];
    lane_t           x_init, y_init;

    // a full quotient only when num equals den, then the remainder is zero
    function automatic lane_t lane_start(swb_pkg::den_t num, swb_pkg::den_t den);
        lane_t o;
        o.den = den;
        o.q   = '0;
        if (num == den)
        begin
            o.q   = swb_pkg::TIME_ONE;
            o.rem = '0;
        end
        else
            o.rem = num;
        return o;
    endfunction

    function automatic lane_t lane_step(lane_t a, int k);
        lane_t o;
        logic [swb_pkg::DEN_BITS:0] r2;
        int j;
        o = a;
        for (int i = 0; i < swb_pkg::DIV_STEP; i++)
        begin
            j = k * swb_pkg::DIV_STEP + i;
            if (j < swb_pkg::TIME_FRAC_BITS)
            begin
                r2 = {o.rem, 1'b0};
                if (r2 >= {1'b0, o.den})
                begin
                    r2 = r2 - {1'b0, o.den};
                    o.q[swb_pkg::TIME_FRAC_BITS-1-j] = 1'b1;
                end
                o.rem = r2[swb_pkg::DEN_BITS-1:0];
            end
        end
        return o;
    endfunction

    always_comb
    begin
        x_init = lane_start(in_front.num_x, in_front.den_x);
        y_init = lane_start(in_front.num_y, in_front.den_y);
        x_next[0] = lane_step(x_init, 0);
        y_next[0] = lane_step(y_init, 0);
        for (int k = 1; k < swb_pkg::DIV_STAGES; k++)
        begin
            x_next[k] = lane_step(x_reg[k-1], k);
            y_next[k] = lane_step(y_reg[k-1], k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < swb_pkg::DIV_STAGES; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < swb_pkg::DIV_STAGES; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg[0] <= in_front;
            for (int k = 1; k < swb_pkg::DIV_STAGES; k++)
                f_reg[k] <= f_reg[k-1];
            for (int k = 0; k < swb_pkg::DIV_STAGES; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
            end
        end
    end

    assign valid = v_reg[swb_pkg::DIV_STAGES-1];
    assign front = f_reg[swb_pkg::DIV_STAGES-1];
    assign tx    = x_reg[swb_pkg::DIV_STAGES-1].q;
    assign ty    = y_reg[swb_pkg::DIV_STAGES-1].q;

endmodule

// File: rtl/swb_back.sv
// swept box collision test: position at entry time, recheck, axis pick, contact length
// depends on swb_pkg; last stage is the output register
module swb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  swb_pkg::front_t in_front,
    input  swb_pkg::time_t  tx,
    input  swb_pkg::time_t  ty,
    output logic            out_valid,
    output swb_pkg::out_t   out_data
);

    typedef logic signed [swb_pkg::PROD_BITS-1:0] prod_t;
    typedef logic signed [swb_pkg::EDGE_BITS:0]   diff_t;

    logic            m_valid_reg;
    swb_pkg::front_t m_front_reg;
    swb_pkg::time_t  m_tx_reg, m_ty_reg;
    prod_t           py_reg, px_reg;
    prod_t           py_next, px_next;
    logic            o_valid_reg;
    swb_pkg::out_t   o_data_reg, o_data_next;

    swb_pkg::edge_t ny, nx, lo, hi;
    logic miss_x, miss_y, cx, cy, vert;
    diff_t ov;

    // y moves by dy up to the x entry time, x by dx up to the y entry time
    always_comb
    begin
        py_next = prod_t'(in_front.dy) * $signed({1'b0, tx});
        px_next = prod_t'(in_front.dx) * $signed({1'b0, ty});
    end

    always_comb
    begin
        ny = m_front_reg.lmb + swb_pkg::edge_t'(py_reg >>> swb_pkg::TIME_FRAC_BITS);
        nx = m_front_reg.lml + swb_pkg::edge_t'(px_reg >>> swb_pkg::TIME_FRAC_BITS);
        miss_x = (ny >= m_front_reg.st_tol) || (ny + m_front_reg.mh <= m_front_reg.sb_tol);
        miss_y = (nx >= m_front_reg.sr_tol) || (nx + m_front_reg.mw <= m_front_reg.sl_tol);
        cx = m_front_reg.cx && !miss_x;
        cy = m_front_reg.cy && !miss_y;
        // ties go to the horizontal axis
        vert = !cx || (cy && (m_ty_reg < m_tx_reg));
        if (vert)
        begin
            lo = (m_front_reg.sl > nx) ? m_front_reg.sl : nx;
            hi = (m_front_reg.sr < nx + m_front_reg.mw) ? m_front_reg.sr : nx + m_front_reg.mw;
        end
        else
        begin
            lo = (m_front_reg.sb > ny) ? m_front_reg.sb : ny;
            hi = (m_front_reg.st < ny + m_front_reg.mh) ? m_front_reg.st : ny + m_front_reg.mh;
        end
        ov = diff_t'(hi) - diff_t'(lo);

        o_data_next = '0;
        if (cx || cy)
        begin
            o_data_next.hit      = 1'b1;
            o_data_next.hit_axis = vert;
            o_data_next.hit_time = vert ? m_ty_reg : m_tx_reg;
            if (ov < 0)
                o_data_next.contact_length = '0;
            else if (ov > diff_t'(swb_pkg::CONTACT_MAX))
                o_data_next.contact_length = swb_pkg::CONTACT_MAX;
            else
                o_data_next.contact_length = ov[swb_pkg::LEN_BITS-1:0];
        end
        o_data_next.touch_left   = m_front_reg.t_left && !miss_x;
        o_data_next.touch_right  = m_front_reg.t_right && !miss_x;
        // a cancelled crossing also drops a one-way landing
        o_data_next.touch_top    = m_front_reg.t_top && !(m_front_reg.crossed_y && miss_y);
        o_data_next.touch_bottom = m_front_reg.t_bot && !(m_front_reg.crossed_y && miss_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= in_valid;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_front_reg <= in_front;
            m_tx_reg    <= tx;
            m_ty_reg    <= ty;
            py_reg      <= py_next;
            px_reg      <= px_next;
            o_data_reg  <= o_data_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

// File: rtl/swept_box_collision_test.sv
// path from input transfer to result: edge tests, divider 4 stages, multiply, resolve
// and output register; one item per cycle unless stalled, set by the divider pipeline
// the whole pipeline holds while a result waits, so ready follows the output register
// reset clears all stage valid bits and loads contact_tolerance with 1
// depends on swb_pkg, swb_front, swb_div, swb_back
module swept_box_collision_test (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  swb_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output swb_pkg::out_t                out_data,
    input  logic                         cfg_write_en,
    input  logic [swb_pkg::TOL_BITS-1:0] cfg_write_data
);

    logic en;
    logic [swb_pkg::TOL_BITS-1:0] tol_reg;
    logic f_valid, d_valid;
    swb_pkg::front_t f_front, d_front;
    swb_pkg::time_t tx, ty;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= swb_pkg::TOL_RESET;
        else if (cfg_write_en)
            tol_reg <= cfg_write_data;
    end

    swb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_data  (in_data),
        .tol      (tol_reg),
        .valid    (f_valid),
        .front    (f_front)
    );

    swb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .in_front (f_front),
        .valid    (d_valid),
        .front    (d_front),
        .tx       (tx),
        .ty       (ty)
    );

    swb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .in_front  (d_front),
        .tx        (tx),
        .ty        (ty),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    a_hit_has_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> (out_data.touch_left || out_data.touch_right ||
                                       out_data.touch_top || out_data.touch_bottom))
        else $error("hit without a side flag");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> !out_data.hit_axis && out_data.hit_time == '0 &&
                                       out_data.contact_length == '0)
        else $error("miss with non-zero result fields");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.hit_time <= swb_pkg::TIME_ONE)
        else $error("entry time above one");

    a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.touch_left && out_data.touch_right) &&
                      !(out_data.touch_top && out_data.touch_bottom))
        else $error("opposite side flags together");

    a_axis_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit && !out_data.hit_axis |->
            (out_data.touch_left || out_data.touch_right))
        else $error("horizontal hit without a horizontal side");

endmodule
